@@ design/bb3_pkg.sv @@
// Shared constants, types and helper functions of the 3x3 box blur stream unit.
`default_nettype none

package bb3_pkg;

    // Line store geometry
    localparam int MAX_WIDTH = 512;
    localparam int ADDR_W    = $clog2(MAX_WIDTH);

    // Field and counter widths
    localparam int PIX_W     = 8;
    localparam int COORD_W   = 9;
    localparam int CNT_W     = 10;
    localparam int CFG_W     = 10;
    localparam int CFG_IDX_W = 1;
    localparam int SUM_W     = 12;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

    // Dimension limits and reset values
    localparam int DIM_MIN      = 3;
    localparam int WIDTH_RESET  = 512;
    localparam int HEIGHT_RESET = 512;

    // Divide by 9: multiply by ceil(2^16 / 9), exact for sums up to 9 * 255
    localparam int RECIP_W     = 13;
    localparam int RECIP_SHIFT = 16;
    localparam logic [RECIP_W-1:0] RECIP_9 = RECIP_W'(7282);

    // Output queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // Word in the read stage (memory data arrives during this stage)
    typedef struct packed {
        logic               res;
        logic               last;
        logic [PIX_W-1:0]   pixel;
        logic [ADDR_W-1:0]  idx;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               fwd_hit;
        logic [PIX_W-1:0]   fwd_top;
        logic [PIX_W-1:0]   fwd_mid;
    } stage_t;

    // Line store write request
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  older;
        logic [PIX_W-1:0]  newer;
    } wr_t;

    // Window sum with its result tags
    typedef struct packed {
        logic [SUM_W-1:0]   sum;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               last;
    } sum_t;

    // Finished result word
    typedef struct packed {
        logic [PIX_W-1:0]   blurred;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               last;
    } result_t;

    // Clamp a configured dimension to DIM_MIN .. MAX_WIDTH
    function automatic logic [CNT_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
        logic [CNT_W-1:0] r;
        if (32'(v) < DIM_MIN)
            r = CNT_W'(DIM_MIN);
        else if (32'(v) > MAX_WIDTH)
            r = CNT_W'(MAX_WIDTH);
        else
            r = CNT_W'(v);
        return r;
    endfunction

    // Sum of the three pixels of one window column
    function automatic logic [SUM_W-1:0] col_sum(input logic [3*PIX_W-1:0] c);
        return SUM_W'(c[PIX_W-1:0]) + SUM_W'(c[2*PIX_W-1:PIX_W])
             + SUM_W'(c[3*PIX_W-1:2*PIX_W]);
    endfunction

endpackage

`default_nettype wire

@@ design/bb3_line_store.sv @@
// Two line stores (older and newer row) with one registered read port and one write port.
`default_nettype none

module bb3_line_store
(
    input  wire logic                       clk,
    input  wire logic                       rd_en,
    input  wire logic [bb3_pkg::ADDR_W-1:0] rd_addr,
    output logic [bb3_pkg::PIX_W-1:0]       rd_older,
    output logic [bb3_pkg::PIX_W-1:0]       rd_newer,
    input  wire bb3_pkg::wr_t               wr
);
    import bb3_pkg::*;

    logic [PIX_W-1:0] older_mem [MAX_WIDTH];
    logic [PIX_W-1:0] newer_mem [MAX_WIDTH];
    logic [PIX_W-1:0] rd_older_reg;
    logic [PIX_W-1:0] rd_newer_reg;

    // Write back the shifted column
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            older_mem[wr.addr] <= wr.older;
            newer_mem[wr.addr] <= wr.newer;
        end
    end

    // Read both rows; the data is registered and ready in the next cycle
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_older_reg <= older_mem[rd_addr];
            rd_newer_reg <= newer_mem[rd_addr];
        end
    end

    assign rd_older = rd_older_reg;
    assign rd_newer = rd_newer_reg;

endmodule

`default_nettype wire

@@ design/bb3_window.sv @@
// Window stage: forward line store data, shift the 3x3 window, sum nine pixels.
`default_nettype none

module bb3_window
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     s1_valid,
    input  wire bb3_pkg::stage_t          s1,
    input  wire logic [bb3_pkg::PIX_W-1:0] rd_older,
    input  wire logic [bb3_pkg::PIX_W-1:0] rd_newer,
    output bb3_pkg::wr_t                  wr,
    output logic                          s2_valid,
    output bb3_pkg::sum_t                 s2
);
    import bb3_pkg::*;

    logic [3*PIX_W-1:0] win0_reg;
    logic [3*PIX_W-1:0] win1_reg;
    logic [PIX_W-1:0]   top;
    logic [PIX_W-1:0]   mid;
    logic [3*PIX_W-1:0] col_now;
    logic [SUM_W-1:0]   sum_next;
    logic               s2_valid_reg;
    sum_t               s2_reg;

    // Take the previous word's write when it hit the same entry
    always_comb
    begin
        top      = s1.fwd_hit ? s1.fwd_top : rd_older;
        mid      = s1.fwd_hit ? s1.fwd_mid : rd_newer;
        col_now  = {s1.pixel, mid, top};
        sum_next = col_sum(win0_reg) + col_sum(win1_reg) + col_sum(col_now);
    end

    // Shift the column down by one row in the line stores
    always_comb
    begin
        wr.en    = s1_valid;
        wr.addr  = s1.idx;
        wr.older = mid;
        wr.newer = s1.pixel;
    end

    // Advance the window by one column
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win0_reg <= '0;
            win1_reg <= '0;
        end
        else if (s1_valid)
        begin
            win0_reg <= win1_reg;
            win1_reg <= col_now;
        end
    end

    // Hold the sum for the divide stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else
            s2_valid_reg <= s1_valid && s1.res;
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid && s1.res)
        begin
            s2_reg.sum  <= sum_next;
            s2_reg.row  <= s1.row;
            s2_reg.col  <= s1.col;
            s2_reg.last <= s1.last;
        end
    end

    assign s2_valid = s2_valid_reg;
    assign s2       = s2_reg;

endmodule

`default_nettype wire

@@ design/bb3_out_fifo.sv @@
// Divide-by-nine and output queue of finished result words.
`default_nettype none

module bb3_out_fifo
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s2_valid,
    input  wire bb3_pkg::sum_t                 s2,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output bb3_pkg::result_t                   head,
    output logic [bb3_pkg::FIFO_CNT_W-1:0]     count
);
    import bb3_pkg::*;

    result_t                     mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]       wr_ptr_reg;
    logic [FIFO_PTR_W-1:0]       rd_ptr_reg;
    logic [FIFO_CNT_W-1:0]       count_reg;
    logic [SUM_W+RECIP_W-1:0]    prod;
    result_t                     entry;
    logic                        pop;

    // Divide by nine through the reciprocal, truncated
    always_comb
    begin
        prod          = (SUM_W+RECIP_W)'(s2.sum) * (SUM_W+RECIP_W)'(RECIP_9);
        entry.blurred = prod[RECIP_SHIFT +: PIX_W];
        entry.row     = s2.row;
        entry.col     = s2.col;
        entry.last    = s2.last;
    end

    assign pop = out_valid && out_ready;

    // Store the new word
    always_ff @(posedge clk)
    begin
        if (s2_valid)
            mem_reg[wr_ptr_reg] <= entry;
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (s2_valid)
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            if (s2_valid && !pop)
                count_reg <= count_reg + FIFO_CNT_W'(1);
            else if (!s2_valid && pop)
                count_reg <= count_reg - FIFO_CNT_W'(1);
        end
    end

    assign out_valid = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];
    assign count     = count_reg;

endmodule

`default_nettype wire

@@ design/box_blur_3x3_stream_unit.sv @@
// Top level of the streaming 3x3 box blur: counters, read stage and channel control.
//
//  channel   signals                                         direction
//  input     in_valid, in_ready, pixel, start_of_frame        into block
//  output    out_valid, out_ready, blurred, center_row,       out of block
//            center_col, last_of_frame
//  config    cfg_we, cfg_index, cfg_data                      into block
//
// One pixel is taken per clock while in_ready is high. A word reads the line stores at the
// edge that takes it, then passes the read stage register and the window sum register and
// is written into the output queue, whose head drives the output. Back-to-back pixels to
// the same line store entry take the pending write. Reset clears counters, window and
// queue; the line stores are not reset. in_ready is low while queued words plus results in
// flight fill the 4-word queue; it rises after a word leaves.
`default_nettype none

module box_blur_3x3_stream_unit
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [bb3_pkg::PIX_W-1:0]      pixel,
    input  wire logic                           start_of_frame,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [bb3_pkg::PIX_W-1:0]           blurred,
    output logic [bb3_pkg::COORD_W-1:0]         center_row,
    output logic [bb3_pkg::COORD_W-1:0]         center_col,
    output logic                                last_of_frame,
    input  wire logic                           cfg_we,
    input  wire logic [bb3_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [bb3_pkg::CFG_W-1:0]      cfg_data
);
    import bb3_pkg::*;

    logic [CNT_W-1:0]      width_reg;
    logic [CNT_W-1:0]      height_reg;
    logic [CNT_W-1:0]      row_reg;
    logic [CNT_W-1:0]      col_reg;
    logic [CNT_W-1:0]      cur_row;
    logic [CNT_W-1:0]      cur_col;
    logic                  row_end;
    logic                  frame_end;
    logic                  accept;
    logic [ADDR_W-1:0]     idx;
    logic                  s1_valid_reg;
    stage_t                s1_reg;
    stage_t                s1_next;
    wr_t                   wr;
    logic [PIX_W-1:0]      rd_older;
    logic [PIX_W-1:0]      rd_newer;
    logic                  s2_valid;
    sum_t                  s2;
    result_t               head;
    logic [FIFO_CNT_W-1:0] fifo_count;
    logic [FIFO_CNT_W:0]   pending;

    // Hold clamped dimensions on each register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= clamp_dim(CFG_W'(WIDTH_RESET));
            height_reg <= clamp_dim(CFG_W'(HEIGHT_RESET));
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WIDTH:  width_reg  <= clamp_dim(cfg_data);
                REG_HEIGHT: height_reg <= clamp_dim(cfg_data);
                default:    ;
            endcase
        end
    end

    // Admit a word only when the queue has room for everything in flight
    assign pending  = (FIFO_CNT_W+1)'(fifo_count)
                    + (FIFO_CNT_W+1)'(s1_valid_reg && s1_reg.res)
                    + (FIFO_CNT_W+1)'(s2_valid);
    assign in_ready = (32'(pending) < FIFO_DEPTH);
    assign accept   = in_valid && in_ready;

    // Position of this pixel and its row and frame ends
    always_comb
    begin
        cur_row   = start_of_frame ? '0 : row_reg;
        cur_col   = start_of_frame ? '0 : col_reg;
        row_end   = ((CNT_W+1)'(cur_col) + (CNT_W+1)'(1)) >= (CNT_W+1)'(width_reg);
        frame_end = row_end
                 && (((CNT_W+1)'(cur_row) + (CNT_W+1)'(1)) >= (CNT_W+1)'(height_reg));
        if (32'(cur_col) >= MAX_WIDTH)
            idx = ADDR_W'(MAX_WIDTH - 1);
        else
            idx = cur_col[ADDR_W-1:0];
    end

    // Build the read stage word, forwarding the write that lands at the same edge
    always_comb
    begin
        s1_next.res     = (32'(cur_row) >= 2) && (32'(cur_col) >= 2);
        s1_next.last    = frame_end;
        s1_next.pixel   = pixel;
        s1_next.idx     = idx;
        s1_next.row     = COORD_W'(cur_row - CNT_W'(1));
        s1_next.col     = COORD_W'(cur_col - CNT_W'(1));
        s1_next.fwd_hit = wr.en && (wr.addr == idx);
        s1_next.fwd_top = wr.older;
        s1_next.fwd_mid = wr.newer;
    end

    // Advance row and column counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (accept)
        begin
            priority if (frame_end)
            begin
                row_reg <= '0;
                col_reg <= '0;
            end
            else if (row_end)
            begin
                row_reg <= cur_row + CNT_W'(1);
                col_reg <= '0;
            end
            else
            begin
                row_reg <= cur_row;
                col_reg <= cur_col + CNT_W'(1);
            end
        end
    end

    // Read stage register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            s1_reg <= s1_next;
    end

    bb3_line_store u_line_store
    (
        .clk      (clk),
        .rd_en    (accept),
        .rd_addr  (idx),
        .rd_older (rd_older),
        .rd_newer (rd_newer),
        .wr       (wr)
    );

    bb3_window u_window
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s1_valid (s1_valid_reg),
        .s1       (s1_reg),
        .rd_older (rd_older),
        .rd_newer (rd_newer),
        .wr       (wr),
        .s2_valid (s2_valid),
        .s2       (s2)
    );

    bb3_out_fifo u_out_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s2_valid  (s2_valid),
        .s2        (s2),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head),
        .count     (fifo_count)
    );

    assign blurred       = head.blurred;
    assign center_row    = head.row;
    assign center_col    = head.col;
    assign last_of_frame = head.last;

endmodule

`default_nettype wire
